/* sv/dveh_pkg.sv */
// shared types and constants of the distinct value event histogram
package dveh_pkg;

  localparam int unsigned NUM_SIDES_DEF   = 4;
  localparam int unsigned NUM_BUCKETS_DEF = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SIDE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CNT32_W  = 32;
  localparam int unsigned USED_W   = 4;
  localparam int unsigned SIDE_OUTS = 4;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 232;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_RECORD = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_CLEARED = 3'd0,
    STAT_HIT     = 3'd1,
    STAT_NEW     = 3'd2,
    STAT_DROPPED = 3'd3,
    STAT_READ    = 3'd4
  } status_e;

  // update request to the event counters
  typedef struct packed {
    logic              clear;
    logic              record;
    logic [SIDE_W-1:0] side;
  } stats_cmd_t;

endpackage

/* sv/dveh_bucket_ram.sv */
// bucket table memory: one write port, one read port with registered data
module dveh_bucket_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dveh_stats.sv */
// total and per-side event counters
module dveh_stats
  import dveh_pkg::*;
#(
  parameter int unsigned NUM_SIDES = NUM_SIDES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stats_cmd_t         cmd_i,
  output logic [CNT32_W-1:0] total_o,
  output logic [CNT32_W-1:0] side_o [SIDE_OUTS]
);

  localparam int unsigned SIDX_W = (NUM_SIDES > 1) ? $clog2(NUM_SIDES) : 1;

  logic [CNT32_W-1:0] total_q;
  logic [CNT32_W-1:0] side_q [NUM_SIDES];
  logic               side_known;
  logic [SIDX_W-1:0]  side_idx;

  assign side_known = 32'(cmd_i.side) < NUM_SIDES;
  assign side_idx   = SIDX_W'(cmd_i.side);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int i = 0; i < NUM_SIDES; i++) side_q[i] <= '0;
    end else if (cmd_i.clear) begin
      total_q <= '0;
      for (int i = 0; i < NUM_SIDES; i++) side_q[i] <= '0;
    end else if (cmd_i.record) begin
      total_q <= total_q + 1'b1;
      if (side_known) begin
        side_q[side_idx] <= side_q[side_idx] + 1'b1;
      end
    end
  end

  assign total_o = total_q;

  for (genvar j = 0; j < SIDE_OUTS; j++) begin : g_side_out
    if (j < NUM_SIDES) begin : g_real
      assign side_o[j] = side_q[j];
    end else begin : g_none
      assign side_o[j] = '0;
    end
  end

endmodule

/* sv/distinct_value_event_histogram.sv */
// top level: op sequencer over the bucket memory, counters and result register
//
// channel   dir  tuser         tdata
// s_axis    in   op            side, event_value, read_slot
// m_axis    out  status        slot .. side3_events
//
// a clear, a record into an empty table and a read of an unused bucket go from idle straight
// to the result state; a read of a used bucket passes through the read-wait state first; any
// other record scans the buckets in use from slot 0 until a hit or the last one in use.
// one op is in work at a time; the next is accepted the cycle after the result enters
// the output register, which may wait on m_axis_tready.
// reset empties the table by zeroing the fill count; entries above it read as zero.
module distinct_value_event_histogram
  import dveh_pkg::*;
#(
  parameter int unsigned NUM_SIDES   = NUM_SIDES_DEF,
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [OP_W-1:0]       s_axis_tuser,  // op
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // side, event_value, read_slot, zero pad
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [STATUS_W-1:0]   m_axis_tuser,  // status
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // slot, entry_valid, entry_key, entry_count,
                                               // total_events, buckets_used, side0..3_events
);

  localparam int unsigned IDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned MEM_W = VALUE_W + CNT32_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RDWAIT,
    ST_RESULT
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     idx_q;
  logic [CNT_W-1:0]     used_q;
  logic [VALUE_W-1:0]   val_q;
  status_e              res_status_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic                 res_valid_q;
  logic [VALUE_W-1:0]   res_key_q;
  logic [CNT32_W-1:0]   res_count_q;
  logic                 m_valid_q;
  logic [STATUS_W-1:0]  m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic [SIDE_W-1:0]    in_side;
  logic [VALUE_W-1:0]   in_value;
  logic [SLOT_W-1:0]    in_rslot;
  op_e                  in_op;
  logic                 accept;

  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  logic [MEM_W-1:0]     ram_wdata, ram_rdata;
  logic [VALUE_W-1:0]   rd_key;
  logic [CNT32_W-1:0]   rd_count;
  logic                 hit, last, has_room, slot_ok, out_load;

  stats_cmd_t           stats_cmd;
  logic [CNT32_W-1:0]   total;
  logic [CNT32_W-1:0]   side_cnt [SIDE_OUTS];

  assign in_op    = op_e'(s_axis_tuser);
  assign in_side  = s_axis_tdata[2:0];
  assign in_value = s_axis_tdata[34:3];
  assign in_rslot = s_axis_tdata[37:35];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rd_key   = ram_rdata[MEM_W-1:CNT32_W];
  assign rd_count = ram_rdata[CNT32_W-1:0];
  assign hit      = (rd_key == val_q);
  assign last     = (CNT_W'(idx_q) + 1'b1) == used_q;
  assign has_room = 32'(used_q) < NUM_BUCKETS;
  assign slot_ok  = 32'(in_rslot) < 32'(used_q);
  assign out_load = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rd_key, rd_count + 1'b1};
    ram_re    = 1'b0;
    ram_raddr = '0;
    stats_cmd = '{clear: 1'b0, record: 1'b0, side: in_side};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          stats_cmd.clear  = (in_op == OP_CLEAR);
          stats_cmd.record = (in_op == OP_RECORD);
          if (in_op == OP_RECORD) begin
            if (used_q == '0) begin
              // empty table: first value fills bucket 0 at once
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_value, CNT32_W'(1)};
            end else begin
              ram_re = 1'b1;
            end
          end else if (in_op == OP_READ && slot_ok) begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(in_rslot);
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          ram_we = 1'b1;
        end else if (!last) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + 1'b1;
        end else if (has_room) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(used_q);
          ram_wdata = {val_q, CNT32_W'(1)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      used_q       <= '0;
      val_q        <= '0;
      res_status_q <= STAT_CLEARED;
      res_slot_q   <= '0;
      res_valid_q  <= 1'b0;
      res_key_q    <= '0;
      res_count_q  <= '0;
      m_valid_q    <= 1'b0;
      m_user_q     <= '0;
      m_data_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            val_q <= in_value;
            idx_q <= '0;
            case (in_op)
              OP_CLEAR: begin
                used_q       <= '0;
                res_status_q <= STAT_CLEARED;
                res_slot_q   <= '0;
                res_valid_q  <= 1'b0;
                res_key_q    <= '0;
                res_count_q  <= '0;
                state_q      <= ST_RESULT;
              end
              OP_RECORD: begin
                if (used_q == '0) begin
                  used_q       <= CNT_W'(1);
                  res_status_q <= STAT_NEW;
                  res_slot_q   <= '0;
                  res_valid_q  <= 1'b1;
                  res_key_q    <= in_value;
                  res_count_q  <= CNT32_W'(1);
                  state_q      <= ST_RESULT;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              OP_READ: begin
                res_status_q <= STAT_READ;
                res_slot_q   <= in_rslot;
                if (slot_ok) begin
                  state_q <= ST_RDWAIT;
                end else begin
                  // unused or out-of-range bucket reads as empty
                  res_valid_q <= 1'b0;
                  res_key_q   <= '0;
                  res_count_q <= '0;
                  state_q     <= ST_RESULT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (hit) begin
            res_status_q <= STAT_HIT;
            res_slot_q   <= SLOT_W'(idx_q);
            res_valid_q  <= 1'b1;
            res_key_q    <= rd_key;
            res_count_q  <= rd_count + 1'b1;
            state_q      <= ST_RESULT;
          end else if (!last) begin
            idx_q <= idx_q + 1'b1;
          end else if (has_room) begin
            res_status_q <= STAT_NEW;
            res_slot_q   <= SLOT_W'(used_q);
            res_valid_q  <= 1'b1;
            res_key_q    <= val_q;
            res_count_q  <= CNT32_W'(1);
            used_q       <= used_q + 1'b1;
            state_q      <= ST_RESULT;
          end else begin
            res_status_q <= STAT_DROPPED;
            res_slot_q   <= '0;
            res_valid_q  <= 1'b0;
            res_key_q    <= '0;
            res_count_q  <= '0;
            state_q      <= ST_RESULT;
          end
        end
        ST_RDWAIT: begin
          res_valid_q <= 1'b1;
          res_key_q   <= rd_key;
          res_count_q <= rd_count;
          state_q     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_status_q;
            m_data_q  <= {side_cnt[3], side_cnt[2], side_cnt[1], side_cnt[0],
                          USED_W'(used_q), total, res_count_q, res_key_q,
                          res_valid_q, res_slot_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  dveh_bucket_ram #(
    .DEPTH (NUM_BUCKETS),
    .AW    (IDX_W),
    .DW    (MEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dveh_stats #(
    .NUM_SIDES (NUM_SIDES)
  ) u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (stats_cmd),
    .total_o (total),
    .side_o  (side_cnt)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= NUM_BUCKETS)
    else $error("bucket fill count beyond table size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OP_CLEAR) |=> (used_q == '0 && total == '0))
    else $error("clear left statistics behind");

  a_write_ends_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == ST_RESULT))
    else $error("bucket write not followed by result");

  a_new_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == STAT_NEW) |-> (res_count_q == CNT32_W'(1) && res_valid_q))
    else $error("new bucket result malformed");

endmodule

/* tb/distinct_value_event_histogram_tb.sv */
// self-checking stream testbench for the distinct value event histogram
module distinct_value_event_histogram_tb
  import dveh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB         = NUM_BUCKETS_DEF;
  localparam int NS         = NUM_SIDES_DEF;
  localparam int RAND_ITEMS = 1025;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 150;

  // one input word
  typedef struct {
    op_e         op;
    logic [2:0]  side;
    logic [31:0] value;
    logic [2:0]  rslot;
    int          gap;
    bit          pause;
  } hist_op_t;

  // laid out as m_axis_tdata, slot in the lowest bits
  typedef struct packed {
    logic [31:0] side3;
    logic [31:0] side2;
    logic [31:0] side1;
    logic [31:0] side0;
    logic [3:0]  used;
    logic [31:0] total;
    logic [31:0] count;
    logic [31:0] key;
    logic        valid;
    logic [2:0]  slot;
  } hist_word_t;

  typedef struct packed {
    status_e    status;
    hist_word_t word;
  } hist_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OP_W-1:0]       s_axis_tuser = '0;  // op
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // side, event_value, read_slot, zero pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [STATUS_W-1:0]   m_axis_tuser;       // status
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // slot, entry_valid, entry_key, entry_count,
                                             // total_events, buckets_used, side0..3_events

  distinct_value_event_histogram i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  hist_op_t     op_queue[$];
  hist_result_t expected_results[$];
  int           n_errors = 0;
  int           n_results = 0;

  // shadow of the counters and bucket table
  logic [31:0] total_q;
  logic [31:0] side_q[NS];
  logic [31:0] key_q[NB];
  logic [31:0] cnt_q[NB];
  logic [3:0]  used_q;

  task automatic clear_shadow();
    total_q = '0;
    used_q  = '0;
    for (int s = 0; s < NS; s++) side_q[s] = '0;
    for (int b = 0; b < NB; b++) begin
      key_q[b] = '0;
      cnt_q[b] = '0;
    end
  endtask

  task automatic predict_histogram(input hist_op_t it);
    hist_result_t r;
    int hit;
    r = '0;
    hit = -1;
    case (it.op)
      OP_CLEAR: begin
        clear_shadow();
        r.status = STAT_CLEARED;
      end
      OP_RECORD: begin
        total_q = total_q + 1;
        if (it.side < NS) side_q[it.side[1:0]] = side_q[it.side[1:0]] + 1;
        for (int b = 0; b < NB; b++) begin
          if (hit < 0 && b < used_q && key_q[b] == it.value) hit = b;
        end
        if (hit >= 0) begin
          cnt_q[3'(hit)] = cnt_q[3'(hit)] + 1;
          r.status       = STAT_HIT;
          r.word.slot    = 3'(hit);
          r.word.valid   = 1'b1;
          r.word.key     = key_q[3'(hit)];
          r.word.count   = cnt_q[3'(hit)];
        end else if (used_q < NB) begin
          key_q[used_q[2:0]] = it.value;
          cnt_q[used_q[2:0]] = 32'd1;
          r.status      = STAT_NEW;
          r.word.slot   = 3'(used_q);
          r.word.valid  = 1'b1;
          r.word.key    = it.value;
          r.word.count  = 32'd1;
          used_q        = used_q + 4'd1;
        end else begin
          r.status = STAT_DROPPED;
        end
      end
      OP_READ: begin
        r.status     = STAT_READ;
        r.word.slot  = it.rslot;
        r.word.valid = (it.rslot < used_q);
        r.word.key   = key_q[it.rslot];
        r.word.count = cnt_q[it.rslot];
      end
      default: ;
    endcase
    r.word.total = total_q;
    r.word.used  = used_q;
    r.word.side0 = side_q[0];
    r.word.side1 = side_q[1];
    r.word.side2 = side_q[2];
    r.word.side3 = side_q[3];
    // the unused op code returns nothing
    if (it.op != OP_NONE) expected_results.push_back(r);
  endtask

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // ---------------- stimulus ----------------
  int          item_idx = 0;
  bit          tx_burst = 1'b0;
  logic [31:0] key_pool[12];
  int          pool_n = 4;

  task automatic push_item(input op_e op, input logic [2:0] side, input logic [31:0] value,
                           input logic [2:0] rslot);
    hist_op_t it;
    if (item_idx % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
    it.op    = op;
    it.side  = side;
    it.value = value;
    it.rslot = rslot;
    it.gap   = tx_burst ? 0 : $urandom_range(0, 3);
    // let the block drain completely now and then
    it.pause = (item_idx % 400 == 100);
    op_queue.push_back(it);
    item_idx++;
  endtask

  task automatic refill_pool();
    pool_n = $urandom_range(4, 12);
    for (int k = 0; k < 12; k++) begin
      case ($urandom_range(0, 9))
        0:       key_pool[k] = '0;
        1:       key_pool[k] = '1;
        default: key_pool[k] = $urandom;
      endcase
    end
  endtask

  task automatic build_stimulus();
    int n_rand;
    int pick;
    logic [31:0] val;
    // directed part
    push_item(OP_READ,   3'd0, 32'h0,          3'd0);
    push_item(OP_RECORD, 3'd0, 32'h0000_0000,  3'd0);
    push_item(OP_RECORD, 3'd1, 32'hFFFF_FFFF,  3'd7);
    push_item(OP_RECORD, 3'd2, 32'h0000_0000,  3'd0);
    push_item(OP_RECORD, 3'd3, 32'h8000_0001,  3'd0);
    push_item(OP_RECORD, 3'd4, 32'hFFFF_FFFF,  3'd0);
    push_item(OP_RECORD, 3'd7, 32'h5A5A_5A5A,  3'd0);
    push_item(OP_NONE,   3'd2, 32'h1234_5678,  3'd3);
    push_item(OP_RECORD, 3'd5, 32'h0000_0001,  3'd0);
    push_item(OP_RECORD, 3'd6, 32'h0000_0002,  3'd0);
    push_item(OP_RECORD, 3'd0, 32'h0000_0003,  3'd0);
    push_item(OP_RECORD, 3'd1, 32'h0000_0004,  3'd0);
    push_item(OP_RECORD, 3'd2, 32'h1234_5678,  3'd0);  // table full, dropped
    push_item(OP_RECORD, 3'd3, 32'h0000_0004,  3'd0);  // hit in the last bucket
    push_item(OP_READ,   3'd7, 32'hFFFF_FFFF,  3'd0);
    push_item(OP_READ,   3'd0, 32'h0,          3'd7);
    push_item(OP_READ,   3'd0, 32'h0,          3'd3);
    push_item(OP_CLEAR,  3'd7, 32'hFFFF_FFFF,  3'd7);
    push_item(OP_READ,   3'd0, 32'h0,          3'd7);
    push_item(OP_RECORD, 3'd0, 32'hFFFF_FFFF,  3'd0);
    push_item(OP_READ,   3'd0, 32'h0,          3'd1);  // unused bucket
    push_item(OP_NONE,   3'd7, 32'hFFFF_FFFF,  3'd7);
    push_item(OP_READ,   3'd0, 32'h0,          3'd0);
    // random part, well-formed fill-and-hit runs between clears
    refill_pool();
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_item(OP_CLEAR, 3'($urandom), $urandom, 3'($urandom));
        refill_pool();
        n_rand++;
      end else if (pick < 5) begin
        push_item(OP_NONE, 3'($urandom), $urandom, 3'($urandom));
      end else if (pick < 25) begin
        push_item(OP_READ, 3'($urandom), $urandom, 3'($urandom));
        n_rand++;
      end else begin
        if ($urandom_range(0, 4) == 0) val = $urandom;
        else val = key_pool[$urandom_range(0, pool_n - 1)];
        push_item(OP_RECORD, 3'($urandom), val, 3'($urandom));
        n_rand++;
      end
    end
  endtask

  // ---------------- driver ----------------
  hist_op_t cur_item;
  hist_op_t next_item;
  bit       loaded = 1'b0;
  int       wait_cnt = 0;

  always @(posedge clk_i) begin : drv
    logic nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_histogram(cur_item);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (!loaded && op_queue.size() != 0) begin
          next_item = op_queue.pop_front();
          wait_cnt  = next_item.gap;
          loaded    = 1'b1;
        end
        if (loaded) begin
          if (next_item.pause && expected_results.size() != 0) begin
            // hold until every result is back
          end else if (wait_cnt > 0) begin
            wait_cnt--;
          end else begin
            cur_item     = next_item;
            loaded       = 1'b0;
            nxt_valid    = 1'b1;
            s_axis_tuser <= cur_item.op;
            s_axis_tdata <= {2'b00, cur_item.rslot, cur_item.value, cur_item.side};
          end
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // ---------------- monitor ----------------
  bit rx_burst = 1'b0;
  int stall_left = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin : mon
    logic         nxt_ready;
    hist_result_t got;
    hist_result_t want;
    nxt_ready = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.word   = hist_word_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_error($sformatf("result word with nothing pending, status %0d",
                                 m_axis_tuser));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            report_error($sformatf({"word %0d: status %0d/%0d slot %0d/%0d valid %0d/%0d ",
                                    "key %h/%h count %h/%h total %h/%h used %0d/%0d ",
                                    "sides %h %h %h %h / %h %h %h %h"},
                                   n_results, want.status, got.status,
                                   want.word.slot, got.word.slot,
                                   want.word.valid, got.word.valid,
                                   want.word.key, got.word.key,
                                   want.word.count, got.word.count,
                                   want.word.total, got.word.total,
                                   want.word.used, got.word.used,
                                   want.word.side0, want.word.side1,
                                   want.word.side2, want.word.side3,
                                   got.word.side0, got.word.side1,
                                   got.word.side2, got.word.side3));
          end
        end
        n_results++;
        if (n_results % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        stall_left = rx_burst ? 0 : $urandom_range(0, 3);
        // long back-pressure so the block fills and stalls its input
        if (n_results == HOLD_AT) hold_left = HOLD_LEN;
        if (stall_left != 0 || hold_left != 0) nxt_ready = 1'b0;
      end else if (!m_axis_tready) begin
        if (hold_left > 0) hold_left--;
        else if (stall_left > 0) stall_left--;
        else nxt_ready = 1'b1;
      end
    end
    m_axis_tready <= nxt_ready;
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    clear_shadow();
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (op_queue.size() != 0 || loaded || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
